// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules; included by irdpl_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/irdpl_pkg.sv
// Types, breakpoint tables and constants of the IR distance linearizer.
`timescale 1ns / 1ps

package irdpl_pkg;

  localparam int SEGS   = 10;
  localparam int MV_W   = 16;
  localparam int CM_W   = 7;
  localparam int OFF_W  = 10;
  localparam int DEN_W  = 10;
  localparam int DROP_W = 5;
  localparam int PROD_W = 14;
  localparam int OUT_W  = 15;

  typedef logic [3:0] seg_t;

  localparam logic [MV_W-1:0] LOW_CUT_MV  = 16'd400;
  localparam logic [MV_W-1:0] HIGH_CUT_MV = 16'd3100;
  localparam logic [CM_W-1:0] LOW_DIST_CM  = 7'd80;
  localparam logic [CM_W-1:0] HIGH_DIST_CM = 7'd5;

  // Lower breakpoint of each usable segment.
  localparam logic [MV_W-1:0] SEG_MV [SEGS] = '{
    16'd400, 16'd600, 16'd700, 16'd900, 16'd1100,
    16'd1300, 16'd1600, 16'd2400, 16'd2700, 16'd3000
  };
  // Upper distance times segment width.
  localparam logic [PROD_W-1:0] SEG_D0DEN [SEGS] = '{
    14'd16000, 14'd5000, 14'd8000, 14'd6000, 14'd5000,
    14'd6000, 14'd12000, 14'd3000, 14'd2400, 14'd1400
  };
  localparam logic [DROP_W-1:0] SEG_DROP [SEGS] = '{
    5'd30, 5'd10, 5'd10, 5'd5, 5'd5, 5'd5, 5'd5, 5'd2, 5'd1, 5'd1
  };
  localparam logic [DEN_W-1:0] SEG_DEN [SEGS] = '{
    10'd200, 10'd100, 10'd200, 10'd200, 10'd200,
    10'd300, 10'd800, 10'd300, 10'd300, 10'd200
  };

  typedef struct packed {
    logic            special;
    logic [CM_W-1:0] cm;
    seg_t            seg;
    logic [OFF_W-1:0] off;
  } item_t;

endpackage

// File: hw/rtl/irdpl_front.sv
// Front end: accepts samples and classifies them into segment and offset.
`timescale 1ns / 1ps

module irdpl_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [irdpl_pkg::MV_W-1:0]  millivolts,
  output logic                        item_valid,
  input  logic                        item_ready,
  output irdpl_pkg::item_t            item
);
  import irdpl_pkg::*;

  logic [SEGS-2:0] above;
  seg_t            seg;
  item_t           item_next;

  always_comb begin
    for (int j = 1; j < SEGS; j++) begin
      above[j-1] = millivolts >= SEG_MV[j];
    end
    seg = seg_t'($countones(above));
    item_next.special = (millivolts < LOW_CUT_MV) || (millivolts > HIGH_CUT_MV);
    item_next.cm      = (millivolts < LOW_CUT_MV) ? LOW_DIST_CM : HIGH_DIST_CM;
    item_next.seg     = seg;
    item_next.off     = item_next.special ? '0 : OFF_W'(millivolts - SEG_MV[seg]);
  end

  assign sample_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_ready) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      item <= item_next;
    end
  end

endmodule

// File: hw/rtl/irdpl_fifo.sv
// Short queue between the classifier and the divider pipeline.
`timescale 1ns / 1ps

module irdpl_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  irdpl_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output irdpl_pkg::item_t out_item
);
  import irdpl_pkg::*;

  localparam int DEPTH = 2;

  item_t      mem [DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = cnt != 2'(DEPTH);
  assign out_valid = cnt != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
  end

endmodule

// File: hw/rtl/irdpl_back.sv
// Back end: numerator build and restoring divider pipeline, one bit per stage.
`timescale 1ns / 1ps

module irdpl_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  irdpl_pkg::item_t            item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [irdpl_pkg::OUT_W-1:0] distance_fixed
);
  import irdpl_pkg::*;
  `include "assert_macros.svh"

  localparam int QW = CM_W + FRAC_BITS;
  localparam int NW = PROD_W + FRAC_BITS;

  logic [DEN_W-1:0] rem [QW+1];
  logic [DEN_W-1:0] dv  [QW+1];
  logic [QW-1:0]    low [QW+1];
  logic [QW-1:0]    quo [QW+1];
  logic [QW:0]      vld;
  logic             en;

  logic [PROD_W-1:0] d0den;
  logic [DROP_W-1:0] drop;
  logic [DEN_W-1:0]  den;
  logic [PROD_W:0]   prod;
  logic [NW-1:0]     numer;
  logic              sat;

  assign en         = !vld[QW] || result_ready;
  assign item_ready = en;

  always_comb begin
    if (item.special) begin
      d0den = PROD_W'(item.cm);
      drop  = '0;
      den   = DEN_W'(1);
    end else begin
      d0den = SEG_D0DEN[item.seg];
      drop  = SEG_DROP[item.seg];
      den   = SEG_DEN[item.seg];
    end
    prod  = (PROD_W + 1)'(drop) * (PROD_W + 1)'(item.off);
    numer = NW'(d0den - prod[PROD_W-1:0]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DEN_W'(numer[NW-1:QW]);
      low[0] <= numer[QW-1:0];
      quo[0] <= '0;
      dv[0]  <= den;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;

    assign t    = {rem[k-1], low[k-1][QW-1]};
    assign ge   = t >= {1'b0, dv[k-1]};
    assign diff = t - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        low[k] <= low[k-1] << 1;
        quo[k] <= {quo[k-1][QW-2:0], ge};
        dv[k]  <= dv[k-1];
      end
    end
  end

  assign sat            = (quo[QW] >> OUT_W) != '0;
  assign result_valid   = vld[QW];
  assign distance_fixed = sat ? '1 : OUT_W'(quo[QW]);

  `ASSERT_ALWAYS(a_rem_first, !vld[0] || (rem[0] < dv[0]), "first remainder not below divisor")
  `ASSERT_ALWAYS(a_rem_last, !vld[QW] || (rem[QW] < dv[QW]), "final remainder not below divisor")
  `ASSERT_NEXT(a_advance, vld[0] && en, vld[1], "transaction dropped in divider pipeline")

endmodule

// File: hw/rtl/ir_distance_piecewise_linear_top.sv
// Top level of the infrared range sensor distance linearizer.
`timescale 1ns / 1ps

// Converts a sensor voltage in millivolts to a distance in centimeters with
// FRAC_BITS fraction bits by piecewise-linear interpolation over a fixed
// breakpoint table; below 400 mV the result is 80 cm, above 3100 mV it is 5 cm,
// and values that do not fit in 15 bits saturate. One transaction is accepted
// per cycle while the output is not stalled. An accepted sample passes through
// the classifier register, the two-entry queue, the register after the
// numerator multiply, and FRAC_BITS + 7 one-bit divider stages.
// Results stay in order; a stalled output holds the whole divider pipeline,
// while the queue and classifier keep taking samples until they fill.
module ir_distance_piecewise_linear_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [irdpl_pkg::MV_W-1:0]  millivolts,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [irdpl_pkg::OUT_W-1:0] distance_fixed
);
  import irdpl_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  front_valid;
  logic  front_ready;
  logic  queue_valid;
  logic  queue_ready;

  irdpl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .millivolts   (millivolts),
    .item_valid   (front_valid),
    .item_ready   (front_ready),
    .item         (front_item)
  );

  irdpl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  irdpl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (queue_valid),
    .item_ready     (queue_ready),
    .item           (queue_item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .distance_fixed (distance_fixed)
  );

endmodule
